// ----- hdl/pcc_pkg.sv -----
// Shared types and constants for the phase DVFS clock classifier.
// Holds the item structs, action and class codes and register indexes.
// Depends on nothing; every other file imports it.
`default_nettype none

package pcc_pkg;

    // Field widths fixed by the item format.
    localparam int PHASE_W     = 6;
    localparam int ACTION_W    = 2;
    localparam int COST_W      = 32;
    localparam int SUM_W       = 48;
    localparam int CLASS_W     = 2;
    localparam int CLOCK_W     = 9;
    localparam int INTENSITY_W = 58;
    localparam int LEVEL_W     = 8;
    localparam int THRESH_W    = 16;

    // Number of phase codes the phase field can address.
    localparam int PHASE_SPAN      = 2 ** PHASE_W;
    localparam int PHASE_COUNT_DEF = 64;

    // Queue between the table side and the divider side.
    localparam int QUEUE_DEPTH = 2;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_ACCUM    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLASSIFY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 2'd2;

    // Class codes.
    localparam logic [CLASS_W-1:0] CLS_BALANCED = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_COMPUTE  = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_MEMORY   = 2'd2;

    // Nominal Q8 clock factor.
    localparam logic [CLOCK_W-1:0] NOMINAL_Q8 = 9'd256;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_THERMAL_LEVEL  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_POWER_LEVEL    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_THERMAL_CAP    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_POWER_CAP      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_THRESHOLD = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LOW_THRESHOLD  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_OVERCLOCK_Q8   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_DOWNCLOCK_Q8   = 3'd7;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [PHASE_W-1:0]  phase;
        logic [COST_W-1:0]   compute_cost;
        logic [COST_W-1:0]   memory_cost;
    } t_in_item;

    typedef struct packed {
        logic [PHASE_W-1:0]     result_phase;
        logic [CLASS_W-1:0]     phase_class;
        logic [CLOCK_W-1:0]     clock_q8;
        logic [INTENSITY_W-1:0] intensity;
    } t_out_item;

    // One classify job handed from the table side to the divider side.
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [SUM_W-1:0]   compute_sum;
        logic [SUM_W-1:0]   memory_sum;
    } t_job;

    typedef struct packed {
        logic [LEVEL_W-1:0]  thermal_level;
        logic [LEVEL_W-1:0]  power_level;
        logic [LEVEL_W-1:0]  thermal_cap;
        logic [LEVEL_W-1:0]  power_cap;
        logic [THRESH_W-1:0] high_threshold;
        logic [THRESH_W-1:0] low_threshold;
        logic [CLOCK_W-1:0]  overclock_q8;
        logic [CLOCK_W-1:0]  downclock_q8;
    } t_cfg;

endpackage

`default_nettype wire

// ----- hdl/pcc_front.sv -----
// Table side: accepts items, keeps the per-phase cost sums and issues classify jobs.
// The sums live in two memories with one valid bit per entry for the clear action.
// Depends on pcc_pkg.
`default_nettype none

module pcc_front #(
    parameter int PHASE_COUNT = pcc_pkg::PHASE_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  pcc_pkg::t_in_item i_in_data,
    output logic              o_in_stall,
    output logic              o_push,
    output pcc_pkg::t_job     o_push_job,
    input  logic              i_q_full
);
    import pcc_pkg::*;

    localparam int DEPTH = (PHASE_COUNT < PHASE_SPAN) ? PHASE_COUNT : PHASE_SPAN;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PHASE_W:0] PHASE_LIMIT = (PHASE_W + 1)'(DEPTH);

    // Sum memories and their valid bits.
    logic [SUM_W-1:0] mem_comp [DEPTH];
    logic [SUM_W-1:0] mem_mem  [DEPTH];
    logic [DEPTH-1:0] r_valid;

    // Second stage: the item and the registered read of its entry.
    logic             r_s1_vld;
    t_in_item         r_s1_item;
    logic [SUM_W-1:0] r_rd_comp;
    logic [SUM_W-1:0] r_rd_mem;
    logic             r_rd_valid;
    logic             r_hit_wr;
    logic             r_hit_clr;
    logic [SUM_W-1:0] r_byp_comp;
    logic [SUM_W-1:0] r_byp_mem;

    logic             w_accept;
    logic             w_s1_fire;
    logic             w_in_table;
    logic             w_is_classify;
    logic             w_wr_en;
    logic             w_clr_en;
    logic [IDX_W-1:0] w_rd_idx;
    logic [IDX_W-1:0] w_wr_idx;
    logic [SUM_W-1:0] w_comp_eff;
    logic [SUM_W-1:0] w_mem_eff;
    logic [SUM_W:0]   w_add_comp;
    logic [SUM_W:0]   w_add_mem;
    logic [SUM_W-1:0] w_sum_comp;
    logic [SUM_W-1:0] w_sum_mem;

    // Second stage decode and handshake.
    assign w_in_table    = ({1'b0, r_s1_item.phase} < PHASE_LIMIT);
    assign w_is_classify = (r_s1_item.action == ACT_CLASSIFY);
    assign w_s1_fire     = r_s1_vld && !(w_is_classify && i_q_full);
    assign o_in_stall    = r_s1_vld && !w_s1_fire;
    assign w_accept      = i_in_valid && !o_in_stall;

    assign w_wr_en  = w_s1_fire && (r_s1_item.action == ACT_ACCUM) && w_in_table;
    assign w_clr_en = w_s1_fire && (r_s1_item.action == ACT_CLEAR);
    assign w_rd_idx = i_in_data.phase[IDX_W-1:0];
    assign w_wr_idx = r_s1_item.phase[IDX_W-1:0];

    // The read missed a write or clear made at its own edge; correct it here.
    always_comb begin
        if (r_hit_wr) begin
            w_comp_eff = r_byp_comp;
            w_mem_eff  = r_byp_mem;
        end else if (!r_hit_clr && r_rd_valid && w_in_table) begin
            w_comp_eff = r_rd_comp;
            w_mem_eff  = r_rd_mem;
        end else begin
            w_comp_eff = '0;
            w_mem_eff  = '0;
        end
    end

    // Saturating accumulation of both sums.
    assign w_add_comp = {1'b0, w_comp_eff} + (SUM_W + 1)'(r_s1_item.compute_cost);
    assign w_add_mem  = {1'b0, w_mem_eff} + (SUM_W + 1)'(r_s1_item.memory_cost);
    assign w_sum_comp = w_add_comp[SUM_W] ? {SUM_W{1'b1}} : w_add_comp[SUM_W-1:0];
    assign w_sum_mem  = w_add_mem[SUM_W] ? {SUM_W{1'b1}} : w_add_mem[SUM_W-1:0];

    // Classify jobs go to the queue with the corrected sums.
    assign o_push                 = w_s1_fire && w_is_classify;
    assign o_push_job.phase       = r_s1_item.phase;
    assign o_push_job.compute_sum = w_comp_eff;
    assign o_push_job.memory_sum  = w_mem_eff;

    // Sum memories: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_comp[w_wr_idx] <= w_sum_comp;
            mem_mem[w_wr_idx]  <= w_sum_mem;
        end
        if (w_accept) begin
            r_rd_comp <= mem_comp[w_rd_idx];
            r_rd_mem  <= mem_mem[w_rd_idx];
        end
    end

    // Valid bits: a clear drops them all at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_clr_en) begin
            r_valid <= '0;
        end else if (w_wr_en) begin
            r_valid[w_wr_idx] <= 1'b1;
        end
    end

    // Second stage occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_accept) begin
            r_s1_vld <= 1'b1;
        end else if (w_s1_fire) begin
            r_s1_vld <= 1'b0;
        end
    end

    // Second stage payload and the bypass capture.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_item  <= i_in_data;
            r_rd_valid <= r_valid[w_rd_idx];
            r_hit_wr   <= w_wr_en && (r_s1_item.phase == i_in_data.phase);
            r_hit_clr  <= w_clr_en;
            r_byp_comp <= w_sum_comp;
            r_byp_mem  <= w_sum_mem;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/pcc_queue.sv -----
// Short job queue that decouples the table side from the divider side.
// Depth comes from the package; entries are classify jobs.
// Depends on pcc_pkg.
`default_nettype none

module pcc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pcc_pkg::t_job i_push_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_head_vld,
    output pcc_pkg::t_job o_head_job
);
    import pcc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_job             r_slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full     = (r_count == CNT_FULL);
    assign o_head_vld = (r_count != '0);
    assign o_head_job = r_slots[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/pcc_back.sv -----
// Divider side: scales the compute sum, divides by the memory sum two bits a cycle,
// then picks the class and clock and holds the word in the output register.
// Depends on pcc_pkg.
`default_nettype none

module pcc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pcc_pkg::t_cfg      i_cfg,
    input  logic               i_job_vld,
    input  pcc_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    output pcc_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);
    import pcc_pkg::*;

    localparam int STEPS = INTENSITY_W / 2;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);
    localparam int RS_W  = SUM_W + 2;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [CNT_W-1:0]       r_cnt;
    logic [PHASE_W-1:0]     r_phase;
    logic [INTENSITY_W-1:0] r_quo;
    logic [SUM_W-1:0]       r_rem;
    logic [SUM_W-1:0]       r_d1;
    logic [RS_W-1:0]        r_d3;
    logic                   r_out_vld;
    t_out_item              r_out;

    logic [INTENSITY_W-1:0] w_prod;
    logic [SUM_W-1:0]       w_dsr;
    logic [RS_W-1:0]        w_dsr3;
    logic [RS_W-1:0]        w_rs;
    logic [RS_W:0]          w_sub1;
    logic [RS_W:0]          w_sub2;
    logic [RS_W:0]          w_sub3;
    logic [1:0]             w_digit;
    logic [SUM_W-1:0]       w_rem_next;
    logic                   w_out_free;
    logic                   w_capped;
    logic [CLASS_W-1:0]     w_class;
    logic [CLOCK_W-1:0]     w_clock;

    // Intensity scale: x*1000 = x*1024 - x*16 - x*8.
    assign w_prod = {i_job.compute_sum, 10'b0}
                    - INTENSITY_W'({i_job.compute_sum, 4'b0})
                    - INTENSITY_W'({i_job.compute_sum, 3'b0});

    // A zero memory sum divides as one.
    assign w_dsr  = (i_job.memory_sum == '0) ? SUM_W'(1) : i_job.memory_sum;
    assign w_dsr3 = RS_W'(w_dsr) + RS_W'({w_dsr, 1'b0});

    // One radix-4 step: compare the partial remainder with d, 2d and 3d.
    assign w_rs   = {r_rem, r_quo[INTENSITY_W-1 -: 2]};
    assign w_sub1 = {1'b0, w_rs} - (RS_W + 1)'(r_d1);
    assign w_sub2 = {1'b0, w_rs} - (RS_W + 1)'({r_d1, 1'b0});
    assign w_sub3 = {1'b0, w_rs} - {1'b0, r_d3};

    always_comb begin
        priority if (!w_sub3[RS_W]) begin
            w_digit    = 2'd3;
            w_rem_next = w_sub3[SUM_W-1:0];
        end else if (!w_sub2[RS_W]) begin
            w_digit    = 2'd2;
            w_rem_next = w_sub2[SUM_W-1:0];
        end else if (!w_sub1[RS_W]) begin
            w_digit    = 2'd1;
            w_rem_next = w_sub1[SUM_W-1:0];
        end else begin
            w_digit    = 2'd0;
            w_rem_next = w_rs[SUM_W-1:0];
        end
    end

    // Class and clock from the finished quotient; the high test wins.
    assign w_capped = (i_cfg.thermal_level >= i_cfg.thermal_cap)
                      || (i_cfg.power_level >= i_cfg.power_cap);

    always_comb begin
        priority if (r_quo >= INTENSITY_W'(i_cfg.high_threshold)) begin
            w_class = CLS_COMPUTE;
            w_clock = w_capped ? NOMINAL_Q8 : i_cfg.overclock_q8;
        end else if (r_quo <= INTENSITY_W'(i_cfg.low_threshold)) begin
            w_class = CLS_MEMORY;
            w_clock = i_cfg.downclock_q8;
        end else begin
            w_class = CLS_BALANCED;
            w_clock = NOMINAL_Q8;
        end
    end

    assign w_out_free = !r_out_vld || !i_out_stall;
    assign o_pop      = (r_state == ST_IDLE) && i_job_vld;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_vld) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Divider datapath.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_phase <= i_job.phase;
            r_quo   <= w_prod;
            r_rem   <= '0;
            r_d1    <= w_dsr;
            r_d3    <= w_dsr3;
            r_cnt   <= '0;
        end else if (r_state == ST_DIV) begin
            r_quo <= {r_quo[INTENSITY_W-3:0], w_digit};
            r_rem <= w_rem_next;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == ST_FIN) && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && w_out_free) begin
            r_out.result_phase <= r_phase;
            r_out.phase_class  <= w_class;
            r_out.clock_q8     <= w_clock;
            r_out.intensity    <= r_quo;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- hdl/phase_dvfs_clock_classifier.sv -----
// Phase DVFS clock classifier: per-phase cost sums with a divide-based classifier.
// Top level holding the configuration registers; instantiates the table side,
// the job queue and the divider side. Depends on pcc_pkg.
`default_nettype none

// The block takes one word per cycle on the input channel unless it stalls.
// Accumulate and clear words pass the two-stage table side at one per cycle,
// back to back unless a classify word stalls ahead of them, with the sums kept
// in a memory and a valid bit per entry (reset and clear take effect at once,
// no clearing pass). A classify word is handed through a two-entry queue to a
// radix-4 divider that retires two quotient bits a cycle in its divide state;
// it loads a job, runs the divide steps and finishes, and takes the next job
// only once back in idle. Accumulates keep flowing while the divider works
// until the queue and the table stage hold classify words. Results leave through
// a registered output that takes a new word only once the previous one is taken.

module phase_dvfs_clock_classifier #(
    parameter int PHASE_COUNT = pcc_pkg::PHASE_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  pcc_pkg::t_in_item              i_in_data,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output pcc_pkg::t_out_item             o_out_data,
    input  logic                           i_out_stall,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pcc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pcc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pcc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import pcc_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_cfg_wr;
    logic                 w_push;
    t_job                 w_push_job;
    logic                 w_q_full;
    logic                 w_pop;
    logic                 w_head_vld;
    t_job                 w_head_job;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[APB_ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thermal_level  <= LEVEL_W'(0);
            r_cfg.power_level    <= LEVEL_W'(0);
            r_cfg.thermal_cap    <= LEVEL_W'(70);
            r_cfg.power_cap      <= LEVEL_W'(70);
            r_cfg.high_threshold <= THRESH_W'(1000);
            r_cfg.low_threshold  <= THRESH_W'(250);
            r_cfg.overclock_q8   <= CLOCK_W'(320);
            r_cfg.downclock_q8   <= CLOCK_W'(192);
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_THERMAL_LEVEL:  r_cfg.thermal_level  <= pwdata[LEVEL_W-1:0];
                REG_POWER_LEVEL:    r_cfg.power_level    <= pwdata[LEVEL_W-1:0];
                REG_THERMAL_CAP:    r_cfg.thermal_cap    <= pwdata[LEVEL_W-1:0];
                REG_POWER_CAP:      r_cfg.power_cap      <= pwdata[LEVEL_W-1:0];
                REG_HIGH_THRESHOLD: r_cfg.high_threshold <= pwdata[THRESH_W-1:0];
                REG_LOW_THRESHOLD:  r_cfg.low_threshold  <= pwdata[THRESH_W-1:0];
                REG_OVERCLOCK_Q8:   r_cfg.overclock_q8   <= pwdata[CLOCK_W-1:0];
                REG_DOWNCLOCK_Q8:   r_cfg.downclock_q8   <= pwdata[CLOCK_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (w_reg_idx)
            REG_THERMAL_LEVEL:  prdata = APB_DATA_W'(r_cfg.thermal_level);
            REG_POWER_LEVEL:    prdata = APB_DATA_W'(r_cfg.power_level);
            REG_THERMAL_CAP:    prdata = APB_DATA_W'(r_cfg.thermal_cap);
            REG_POWER_CAP:      prdata = APB_DATA_W'(r_cfg.power_cap);
            REG_HIGH_THRESHOLD: prdata = APB_DATA_W'(r_cfg.high_threshold);
            REG_LOW_THRESHOLD:  prdata = APB_DATA_W'(r_cfg.low_threshold);
            REG_OVERCLOCK_Q8:   prdata = APB_DATA_W'(r_cfg.overclock_q8);
            REG_DOWNCLOCK_Q8:   prdata = APB_DATA_W'(r_cfg.downclock_q8);
            default:            prdata = '0;
        endcase
    end

    // Table side.
    pcc_front #(
        .PHASE_COUNT(PHASE_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_push_job (w_push_job),
        .i_q_full   (w_q_full)
    );

    // Job queue.
    pcc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_push_job),
        .o_full     (w_q_full),
        .i_pop      (w_pop),
        .o_head_vld (w_head_vld),
        .o_head_job (w_head_job)
    );

    // Divider side.
    pcc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_vld   (w_head_vld),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

// ----- hdl/pcc_checker.sv -----
// Port-level checker for the phase DVFS clock classifier, bound to the top level.
// Tracks classify words in flight and checks the channel behavior over time.
// Depends on pcc_pkg and phase_dvfs_clock_classifier.
`default_nettype none

module pcc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input pcc_pkg::t_in_item i_in_data,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall
);
    import pcc_pkg::*;

    // Table stage, divider and output register each hold at most one; the queue holds QUEUE_DEPTH.
    localparam logic [3:0] MAX_PENDING = 4'(QUEUE_DEPTH + 3);

    logic       w_in_acc;
    logic       w_out_acc;
    logic       w_cls_in;
    logic [3:0] r_pend;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = o_out_valid && !i_out_stall;
    assign w_cls_in  = w_in_acc && (i_in_data.action == ACT_CLASSIFY);

    // Classify words accepted and not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (w_cls_in && !w_out_acc) begin
            r_pend <= r_pend + 1'b1;
        end else if (w_out_acc && !w_cls_in) begin
            r_pend <= r_pend - 1'b1;
        end
    end

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result withdrawn while stalled");

    // Every result answers an earlier classify word.
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> (r_pend != '0))
        else $error("result without a pending classify word");

    // Backpressure bounds the classify words in flight.
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= MAX_PENDING)
        else $error("too many classify words in flight");

    // Input stall only starts right after a word was taken.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(w_in_acc))
        else $error("input stall raised without a new word");

endmodule

bind phase_dvfs_clock_classifier pcc_checker u_pcc_checker (.*);

`default_nettype wire
